// ===== design/gvd_pkg.sv =====
// ----------------------------------------------------------------------------
// gvd_pkg - shared types and constants for the group varint byte decoder
// holds the result word layout and the length field helper
// ----------------------------------------------------------------------------
package gvd_pkg;

	// mask of one length field in the control byte
	localparam logic [1:0] LenMask = 2'h3;

	// one result word
	typedef struct packed {
		logic [31:0] value_out;
		logic [31:0] position;
		logic        value_valid;
		logic        page_end;
		logic        truncated;
	} result_t;

	// length minus one of slot k, most significant pair first
	function automatic logic [1:0] len_code(input logic [7:0] ctrl, input logic [1:0] slot);
		logic [7:0] shifted;
		shifted = ctrl >> {~slot, 1'b0};
		return shifted[1:0] & LenMask;
	endfunction

endpackage

// ===== design/gvd_decode.sv =====
// ----------------------------------------------------------------------------
// gvd_decode - group state and per-byte decode
// holds the group state and forms the result of the byte in the input register
// ----------------------------------------------------------------------------
module gvd_decode (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         in_byte,
	input  logic               last_byte,
	input  logic [31:0]        start_pos,
	output logic               has_result,
	output gvd_pkg::result_t   result
);

	logic        await_q;
	logic [7:0]  control_q;
	logic [1:0]  slot_q;
	logic [1:0]  taken_q;
	logic [23:0] acc_q;
	logic [31:0] count_q;

	logic [1:0]  len_c;
	logic        complete;
	logic        group_done;
	logic [31:0] part;
	logic [31:0] merged;

	assign len_c      = gvd_pkg::len_code(control_q, slot_q);
	assign complete   = !await_q && (taken_q >= len_c);
	assign group_done = complete && (slot_q == 2'd3);

	always_comb begin
		case (taken_q)
			2'd0:    part = {24'h0, in_byte};
			2'd1:    part = {16'h0, in_byte, 8'h0};
			2'd2:    part = {8'h0, in_byte, 16'h0};
			default: part = {in_byte, 24'h0};
		endcase
	end

	assign merged = {8'h0, acc_q} | part;

	assign has_result = complete || last_byte;

	always_comb begin
		result.value_out   = complete ? merged : 32'h0;
		result.position    = complete ? (start_pos + count_q) : 32'h0;
		result.value_valid = complete;
		result.page_end    = last_byte;
		result.truncated   = last_byte && !group_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			await_q   <= 1'b1;
			control_q <= 8'h0;
			slot_q    <= 2'd0;
			taken_q   <= 2'd0;
			acc_q     <= 24'h0;
			count_q   <= 32'h0;
		end else if (step) begin
			if (await_q) begin
				control_q <= in_byte;
			end
			if (last_byte) begin
				await_q <= 1'b1;
				slot_q  <= 2'd0;
				taken_q <= 2'd0;
				acc_q   <= 24'h0;
				count_q <= 32'h0;
			end else if (await_q) begin
				await_q <= 1'b0;
				slot_q  <= 2'd0;
				taken_q <= 2'd0;
				acc_q   <= 24'h0;
			end else if (complete) begin
				acc_q   <= 24'h0;
				taken_q <= 2'd0;
				count_q <= count_q + 32'd1;
				slot_q  <= slot_q + 2'd1;
				if (group_done) begin
					await_q <= 1'b1;
				end
			end else begin
				acc_q   <= merged[23:0];
				taken_q <= taken_q + 2'd1;
			end
		end
	end

endmodule

// ===== design/gvd_out_reg.sv =====
// ----------------------------------------------------------------------------
// gvd_out_reg - result register
// holds one result word until the consumer takes it
// ----------------------------------------------------------------------------
module gvd_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  gvd_pkg::result_t load_data,
	output logic             space,
	output logic             out_valid,
	input  logic             out_ready,
	output gvd_pkg::result_t data
);

	logic             valid_s2;
	gvd_pkg::result_t data_s2;

	// free when empty or being drained this cycle
	assign space = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_s2 <= load_data;
		end
	end

	assign out_valid = valid_s2;
	assign data      = data_s2;

endmodule

// ===== design/group_varint_byte_decoder_top.sv =====
// ----------------------------------------------------------------------------
// group_varint_byte_decoder_top - group varint decoder, one page byte a word
// decodes control and value bytes of a page into numbered values
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------
//  in      | sink      | in_valid / in_ready   | in_byte, last_byte
//  out     | source    | out_valid / out_ready | value_out, position, value_valid,
//          |           |                       | page_end, truncated
//  cfg     | sink      | cfg_we                | cfg_wdata (start_pos)
//
//  one byte word per cycle unless a stalled result holds the input; input and result are registered
//  the input register feeds the decode logic, which feeds the result register
//  a byte that makes no result retires even while the result register is full
//  reset clears all control state; decoding starts expecting a control byte
//  in_ready falls only when a result-making byte waits behind a stalled result
//
module group_varint_byte_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        last_byte,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] value_out,
	output logic [31:0] position,
	output logic        value_valid,
	output logic        page_end,
	output logic        truncated,
	// configuration
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	// start position register
	logic [31:0] start_pos_q;

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	// decode and handshake
	logic             has_result;
	logic             space;
	logic             step;
	gvd_pkg::result_t dec_result;
	gvd_pkg::result_t out_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_pos_q <= 32'h0;
		end else if (cfg_we) begin
			start_pos_q <= cfg_wdata;
		end
	end

	// the byte in stage one retires when it makes no result or the result register has room
	assign step     = valid_s1 && (!has_result || space);
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= last_byte;
		end
	end

	gvd_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.in_byte    (byte_s1),
		.last_byte  (last_s1),
		.start_pos  (start_pos_q),
		.has_result (has_result),
		.result     (dec_result)
	);

	gvd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step && has_result),
		.load_data (dec_result),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.data      (out_data)
	);

	assign value_out   = out_data.value_out;
	assign position    = out_data.position;
	assign value_valid = out_data.value_valid;
	assign page_end    = out_data.page_end;
	assign truncated   = out_data.truncated;

`ifndef SYNTHESIS
	// a truncation flag only comes with a page end
	a_trunc_needs_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!truncated || page_end))
		else $error("truncated without page_end");

	// every result carries a value or a page end
	a_result_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (value_valid || page_end))
		else $error("empty result word");

	// a stalled byte in the input register stays put
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !step) |=> (valid_s1 && $stable(byte_s1) && $stable(last_s1)))
		else $error("input register lost a stalled byte");

	// a stalled byte is one that makes a result behind a full result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && has_result && out_valid && !out_ready))
		else $error("input stalled without cause");
`endif

endmodule

// ===== sim/group_varint_byte_decoder_top_tb.sv =====
// ----------------------------------------------------------------------------
// group_varint_byte_decoder_top_tb - self-checking bench for the page decoder
// a directed table, then random pages of well-formed, cut-short and noisy
// groups, under four pacing modes and several start positions; every result
// word is checked against the table or an in-bench decoder model in arrival order
// ----------------------------------------------------------------------------
module group_varint_byte_decoder_top_tb;

	localparam int CLOCK_HALF    = 5;
	localparam int RESET_CYCLES  = 2;
	// two-stage pipeline, plus margin for a byte that makes no result
	localparam int SETTLE_CYCLES = 4;
	localparam int PHASE_WORDS   = 240;
	localparam int NUM_PHASES    = 8;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int MAX_REPORTS   = 10;

	typedef enum int {
		PACE_FREE,
		PACE_SEND_IDLE,
		PACE_RECV_STALL,
		PACE_BOTH
	} pace_t;

	// one row of the directed table; want is used only where typed is set
	typedef struct packed {
		logic [7:0]       data;
		logic             last;
		logic             typed;
		gvd_pkg::result_t want;
	} stim_row_t;

	localparam gvd_pkg::result_t NO_WORD = '0;
	localparam int DIRECTED_ROWS = 19;

	// want fields: value, position, value_valid, page_end, truncated
	// runs with start_pos just below the wrap point
	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		// control byte: lengths 1, 2, 3, 4
		{8'h1B, 1'b0, 1'b0, NO_WORD},
		{8'hFF, 1'b0, 1'b1, 32'h0000_00FF, 32'hFFFF_FFFE, 1'b1, 1'b0, 1'b0},
		{8'h34, 1'b0, 1'b0, NO_WORD},
		{8'h12, 1'b0, 1'b1, 32'h0000_1234, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0},
		{8'h00, 1'b0, 1'b0, NO_WORD},
		{8'h00, 1'b0, 1'b0, NO_WORD},
		// position wraps to zero
		{8'h80, 1'b0, 1'b1, 32'h0080_0000, 32'h0000_0000, 1'b1, 1'b0, 1'b0},
		{8'hFF, 1'b0, 1'b0, NO_WORD},
		{8'hFF, 1'b0, 1'b0, NO_WORD},
		{8'hFF, 1'b0, 1'b0, NO_WORD},
		// page ends on the fourth value: not truncated
		{8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 1'b1, 1'b0},
		// last byte is itself a control byte
		{8'h00, 1'b1, 1'b1, 32'h0, 32'h0, 1'b0, 1'b1, 1'b1},
		// page ends partway through a four-byte value
		{8'hFF, 1'b0, 1'b0, NO_WORD},
		{8'hAA, 1'b0, 1'b0, NO_WORD},
		{8'h55, 1'b1, 1'b1, 32'h0, 32'h0, 1'b0, 1'b1, 1'b1},
		// numbering restarts; page ends on the third value of a group
		{8'h00, 1'b0, 1'b0, NO_WORD},
		{8'h5A, 1'b0, 1'b0, NO_WORD},
		{8'hA5, 1'b0, 1'b0, NO_WORD},
		{8'h42, 1'b1, 1'b0, NO_WORD}
	};

	localparam logic [31:0] PHASE_START [NUM_PHASES] = '{
		32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'h0000_0000,
		32'h8000_0000, 32'h0000_0001, 32'h0000_0000, 32'h7FFF_FFFF
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  in_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] value_out;
	logic [31:0] position;
	logic        value_valid;
	logic        page_end;
	logic        truncated;
	logic        cfg_we;
	logic [31:0] cfg_wdata;

	// pacing, in percent of cycles
	int send_pct;
	int recv_pct;
	int fail_count;

	// results still owed by the block, oldest first
	gvd_pkg::result_t results_due [$];

	// decoder model state
	logic        dec_await_ctrl;
	logic [7:0]  dec_ctrl;
	logic [1:0]  dec_slot;
	logic [1:0]  dec_taken;
	logic [23:0] dec_acc;
	logic [31:0] dec_count;
	logic [31:0] dec_start_pos;

	group_varint_byte_decoder_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.last_byte  (last_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.value_out  (value_out),
		.position   (position),
		.value_valid(value_valid),
		.page_end   (page_end),
		.truncated  (truncated),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	always #CLOCK_HALF clk = ~clk;

	// back to expecting a control byte, partial value dropped
	function automatic void restart_group();
		dec_await_ctrl = 1'b1;
		dec_slot       = 2'd0;
		dec_taken      = 2'd0;
		dec_acc        = 24'd0;
	endfunction

	// model one accepted byte; returns 1 when the byte makes a result word
	function automatic logic decode_byte(input logic [7:0] data, input logic last,
			output gvd_pkg::result_t word);
		int         sh;
		logic [1:0] len_m1;
		logic [31:0] part;
		logic       group_done;
		word       = '0;
		group_done = 1'b0;
		if (dec_await_ctrl) begin
			dec_ctrl       = data;
			dec_slot       = 2'd0;
			dec_taken      = 2'd0;
			dec_acc        = 24'd0;
			dec_await_ctrl = 1'b0;
		end else begin
			// first value sits in the top bit pair
			sh     = 6 - 2 * int'(dec_slot);
			len_m1 = dec_ctrl[sh +: 2];
			part   = 32'(data) << (8 * int'(dec_taken));
			if (dec_taken >= len_m1) begin
				word.value_out   = {8'h00, dec_acc} | part;
				word.position    = dec_start_pos + dec_count;
				word.value_valid = 1'b1;
				dec_count        = dec_count + 32'd1;
				dec_acc          = 24'd0;
				dec_taken        = 2'd0;
				if (dec_slot == 2'd3) begin
					group_done = 1'b1;
					restart_group();
				end else begin
					dec_slot = dec_slot + 2'd1;
				end
			end else begin
				dec_acc   = dec_acc | part[23:0];
				dec_taken = dec_taken + 2'd1;
			end
		end
		if (last) begin
			word.page_end  = 1'b1;
			word.truncated = !group_done;
			restart_group();
			dec_count = 32'd0;
		end
		return word.value_valid | last;
	endfunction

	// bias towards the byte extremes
	function automatic logic [7:0] pick_byte();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return 8'h00;
		if (roll == 1)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic report_fault(input string what, input gvd_pkg::result_t want,
			input gvd_pkg::result_t got);
		if (fail_count < MAX_REPORTS)
			$display({"%0t %s: want value=%h pos=%h vv=%b end=%b trunc=%b,",
					" got value=%h pos=%h vv=%b end=%b trunc=%b"},
				$time, what, want.value_out, want.position, want.value_valid, want.page_end,
				want.truncated, got.value_out, got.position, got.value_valid, got.page_end,
				got.truncated);
		fail_count++;
	endtask

	// present one byte word, wait for it to be taken, then log what it owes
	task automatic send_word(input logic [7:0] data, input logic last, input logic typed,
			input gvd_pkg::result_t want);
		gvd_pkg::result_t predicted;
		logic             made;
		@(negedge clk);
		// sender idle gap, one coin per cycle
		while ($urandom_range(0, 99) < send_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		in_byte   <= data;
		last_byte <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		made = decode_byte(data, last, predicted);
		if (typed)
			results_due.push_back(want);
		else if (made)
			results_due.push_back(predicted);
	endtask

	// stop sending and let every owed result come out
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
	endtask

	// register write only with the pipeline empty
	task automatic set_start_pos(input logic [31:0] value);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we        <= 1'b0;
		dec_start_pos  = value;
	endtask

	// random pages: mostly well-formed groups, some cut short, some noise
	task automatic run_random(input int n_words);
		logic [7:0] page [$];
		logic       ends [$];
		logic [7:0] ctrl;
		int         sent;
		int         kind;
		int         cut;
		logic       paused;
		sent   = 0;
		paused = 1'b0;
		while (sent < n_words) begin
			page.delete();
			ends.delete();
			kind = $urandom_range(0, 99);
			if (kind < 85) begin
				repeat ($urandom_range(1, 4)) begin
					ctrl = 8'($urandom_range(0, 255));
					page.push_back(ctrl);
					for (int k = 0; k < 4; k++)
						repeat (ctrl[6 - 2 * k +: 2] + 1)
							page.push_back(pick_byte());
				end
				// broken page: ends anywhere in the stream of groups
				if (kind >= 70) begin
					cut = $urandom_range(1, page.size());
					while (page.size() > cut)
						void'(page.pop_back());
				end
			end else begin
				// noise with stray page ends
				repeat ($urandom_range(1, 12)) begin
					page.push_back(pick_byte());
					ends.push_back($urandom_range(0, 4) == 0);
				end
			end
			foreach (page[i])
				send_word(page[i], (kind < 85) ? (i == page.size() - 1) : ends[i], 1'b0,
					NO_WORD);
			sent += page.size();
			// hold the sender once per phase until the block has emptied
			if (!paused && sent >= n_words / 2) begin
				wait_drained();
				paused = 1'b1;
			end
		end
	endtask

	// receiver: stall per cycle at the phase's rate
	always @(negedge clk)
		out_ready <= ($urandom_range(0, 99) >= recv_pct);

	// scoreboard: each taken result against the oldest owed one
	always @(posedge clk) begin : result_check
		gvd_pkg::result_t got;
		gvd_pkg::result_t want;
		if (arst_n && out_valid && out_ready) begin
			got.value_out   = value_out;
			got.position    = position;
			got.value_valid = value_valid;
			got.page_end    = page_end;
			got.truncated   = truncated;
			if (results_due.size() == 0) begin
				report_fault("result with nothing owed", NO_WORD, got);
			end else begin
				want = results_due.pop_front();
				if (got.value_out !== want.value_out || got.position !== want.position ||
						got.value_valid !== want.value_valid ||
						got.page_end !== want.page_end || got.truncated !== want.truncated)
					report_fault("result differs", want, got);
			end
		end
	end

	// watchdog
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("group_varint_byte_decoder_top: mismatch");
		$finish;
	end

	initial begin
		clk        = 1'b0;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_byte    = 8'h00;
		last_byte  = 1'b0;
		out_ready  = 1'b0;
		cfg_we     = 1'b0;
		cfg_wdata  = 32'h0;
		send_pct   = 0;
		recv_pct   = 0;
		fail_count = 0;
		// model starts where reset leaves the block
		restart_group();
		dec_ctrl      = 8'h00;
		dec_count     = 32'd0;
		dec_start_pos = 32'd0;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// directed table, no pacing
		set_start_pos(32'hFFFF_FFFE);
		foreach (DIRECTED[i])
			send_word(DIRECTED[i].data, DIRECTED[i].last, DIRECTED[i].typed, DIRECTED[i].want);

		// random phases: new start position and pacing each time
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			if (phase == 3 || phase == 6)
				set_start_pos($urandom);
			else
				set_start_pos(PHASE_START[phase]);
			case (pace_t'(phase % 4))
				PACE_FREE: begin
					send_pct = 0;
					recv_pct = 0;
				end
				PACE_SEND_IDLE: begin
					send_pct = 85;
					recv_pct = 0;
				end
				PACE_RECV_STALL: begin
					send_pct = 0;
					recv_pct = 85;
				end
				default: begin
					send_pct = 17;
					recv_pct = 17;
				end
			endcase
			run_random(PHASE_WORDS);
		end

		// drain, then give any stray result time to show up
		wait_drained();
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && results_due.size() == 0)
			$display("group_varint_byte_decoder_top: match");
		else
			$display("group_varint_byte_decoder_top: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
design/gvd_pkg.sv
design/gvd_decode.sv
design/gvd_out_reg.sv
design/group_varint_byte_decoder_top.sv
sim/group_varint_byte_decoder_top_tb.sv
